### design/hsb_pkg.sv
// Shared types and constants of the hardware spinlock bank.
// Used by the channel interfaces, the address decoder, the top level and the checker.
package hsb_pkg;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_W    = ADDR_W - 2;

    localparam logic [DATA_W-1:0] CLEAR_MAGIC = 32'h454e_434c;

    localparam logic [ADDR_W-1:0] OFF_CLEAR   = 12'h000;
    localparam logic [ADDR_W-1:0] OFF_STATUS  = 12'h004;
    localparam logic [ADDR_W-1:0] OFF_DETAIL  = 12'h008;
    localparam logic [ADDR_W-1:0] OFF_CLEAREN = 12'h00c;
    localparam logic [ADDR_W-1:0] OFF_VERSION = 12'hffc;
    localparam logic [ADDR_W-1:0] TOKEN0_BASE = 12'h080;
    localparam logic [ADDR_W-1:0] TOKEN1_BASE = 12'h800;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCK_VERSION = 2'd0,
        CFG_FREE_V0      = 2'd1,
        CFG_FREE_V1      = 2'd2,
        CFG_VERSION_ID   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        KIND_CLEAR    = 3'd0,
        KIND_STATUS   = 3'd1,
        KIND_DETAIL   = 3'd2,
        KIND_CLEAR_EN = 3'd3,
        KIND_VERSION  = 3'd4,
        KIND_TOKEN    = 3'd5,
        KIND_UNMAPPED = 3'd6
    } t_reg_kind;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

### design/hsb_req_if.sv
// Request channel of the spinlock bank: one bus access per transfer.
// Depends on hsb_pkg for field widths.
interface hsb_req_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [hsb_pkg::ADDR_W-1:0]  address;
    logic [hsb_pkg::DATA_W-1:0]  write_data;
    logic [hsb_pkg::DATA_W-1:0]  requester_key;

    modport source (output valid, opcode, address, write_data, requester_key, input ready);
    modport sink   (input valid, opcode, address, write_data, requester_key, output ready);
endinterface

### design/hsb_rsp_if.sv
// Response channel of the spinlock bank: one result per bus access.
// Depends on hsb_pkg for field widths.
interface hsb_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [hsb_pkg::DATA_W-1:0]  read_data;
    logic                        access_error;

    modport source (output valid, read_data, access_error, input ready);
    modport sink   (input valid, read_data, access_error, output ready);
endinterface

### design/hsb_decode.sv
// Address decoder of the spinlock bank: register kind and lock index of an access.
// Depends on hsb_pkg.
module hsb_decode #(
    parameter int LOCK_COUNT = 32,
    parameter int IDX_W      = 5
) (
    input  logic [hsb_pkg::ADDR_W-1:0] i_address,
    input  logic                       i_lock_version,
    output hsb_pkg::t_reg_kind         o_kind,
    output logic [IDX_W-1:0]           o_idx
);

    logic [hsb_pkg::ADDR_W-1:0] addr_w;
    logic [hsb_pkg::ADDR_W-1:0] base;
    logic [hsb_pkg::ADDR_W-1:0] offset;
    logic [hsb_pkg::WORD_W-1:0] word;
    logic                       token_hit;

    always_comb begin
        // low two bits never take part in decoding
        addr_w    = {i_address[hsb_pkg::ADDR_W-1:2], 2'b00};
        base      = i_lock_version ? hsb_pkg::TOKEN1_BASE : hsb_pkg::TOKEN0_BASE;
        offset    = addr_w - base;
        word      = offset[hsb_pkg::ADDR_W-1:2];
        token_hit = (addr_w >= base) && (word < hsb_pkg::WORD_W'(LOCK_COUNT));
        o_idx     = word[IDX_W-1:0];

        priority if (addr_w == hsb_pkg::OFF_CLEAR) begin
            o_kind = hsb_pkg::KIND_CLEAR;
        end else if (addr_w == hsb_pkg::OFF_STATUS) begin
            o_kind = hsb_pkg::KIND_STATUS;
        end else if (addr_w == hsb_pkg::OFF_DETAIL) begin
            o_kind = hsb_pkg::KIND_DETAIL;
        end else if (addr_w == hsb_pkg::OFF_CLEAREN) begin
            o_kind = hsb_pkg::KIND_CLEAR_EN;
        end else if (addr_w == hsb_pkg::OFF_VERSION) begin
            o_kind = hsb_pkg::KIND_VERSION;
        end else if (token_hit) begin
            o_kind = hsb_pkg::KIND_TOKEN;
        end else begin
            o_kind = hsb_pkg::KIND_UNMAPPED;
        end
    end

endmodule

### design/hardware_spinlock_bank_unit.sv
// Top level of the hardware spinlock bank: taken bits, owner-key memory, register map.
// Depends on hsb_pkg, hsb_req_if, hsb_rsp_if and hsb_decode.
//
//   port     dir  handshake        carries
//   i_req    in   valid/ready      opcode, address, write_data, requester_key
//   o_rsp    out  valid/ready      read_data, access_error
//   i_cfg_*  in   write enable     register index, write data (no read-back)
//
// In the accept cycle the owner-key memory is read into a register; in the execute
// state the access is modified, written back and loaded into the output register.
// A waiting result does not block the next accept; a second result waits in
// the execute cycle until the output register empties.
// Reset (synchronous, active low) frees every lock and disarms the clear register;
// the owner-key memory needs no clearing since it is read only for taken locks.
module hardware_spinlock_bank_unit #(
    parameter int LOCK_COUNT = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hsb_req_if.sink                       i_req,
    hsb_rsp_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [hsb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hsb_pkg::DATA_W-1:0]    i_cfg_wdata
);

    localparam int IDX_W = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;

    // configuration
    logic                       r_lock_version;
    logic [hsb_pkg::DATA_W-1:0] r_free_v0;
    logic [hsb_pkg::DATA_W-1:0] r_free_v1;
    logic [hsb_pkg::DATA_W-1:0] r_version_id;

    // lock state
    logic [LOCK_COUNT-1:0]      r_taken;
    logic [LOCK_COUNT-1:0]      n_taken;
    logic                       r_clear_armed;
    logic                       n_clear_armed;
    logic [hsb_pkg::DATA_W-1:0] mem_owner [LOCK_COUNT];
    logic [hsb_pkg::DATA_W-1:0] r_mem_rdata;
    logic                       mem_we;
    logic [hsb_pkg::DATA_W-1:0] mem_wdata;

    // captured access
    hsb_pkg::t_state            r_state;
    logic                       r_op;
    hsb_pkg::t_reg_kind         r_kind;
    logic [IDX_W-1:0]           r_idx;
    logic [hsb_pkg::DATA_W-1:0] r_wdata;
    logic [hsb_pkg::DATA_W-1:0] r_req_key;

    // output register
    logic                       r_out_valid;
    logic [hsb_pkg::DATA_W-1:0] r_out_rdata;
    logic                       r_out_err;

    hsb_pkg::t_reg_kind         dec_kind;
    logic [IDX_W-1:0]           dec_idx;
    logic                       accept;
    logic                       fire;
    logic                       is_write;
    logic                       lock_hit;
    logic [hsb_pkg::DATA_W-1:0] res_rdata;
    logic                       res_err;

    hsb_decode #(
        .LOCK_COUNT (LOCK_COUNT),
        .IDX_W      (IDX_W)
    ) u_decode (
        .i_address      (i_req.address),
        .i_lock_version (r_lock_version),
        .o_kind         (dec_kind),
        .o_idx          (dec_idx)
    );

    assign i_req.ready        = (r_state == hsb_pkg::S_IDLE);
    assign accept             = i_req.valid && i_req.ready;
    assign fire               = (r_state == hsb_pkg::S_EXEC) && (!r_out_valid || o_rsp.ready);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.read_data    = r_out_rdata;
    assign o_rsp.access_error = r_out_err;

    // modify step of the captured access
    always_comb begin
        is_write      = (r_op == hsb_pkg::OP_WRITE);
        lock_hit      = r_taken[r_idx];
        n_taken       = r_taken;
        n_clear_armed = r_clear_armed;
        mem_we        = 1'b0;
        mem_wdata     = r_wdata;
        res_rdata     = '0;
        res_err       = 1'b0;

        unique case (r_kind)
            hsb_pkg::KIND_CLEAR: begin
                if (is_write && r_clear_armed) begin
                    n_taken = r_taken & ~r_wdata[LOCK_COUNT-1:0];
                end
            end
            hsb_pkg::KIND_STATUS: begin
                res_rdata = hsb_pkg::DATA_W'(|r_taken);
            end
            hsb_pkg::KIND_DETAIL: begin
                res_rdata = hsb_pkg::DATA_W'(r_taken);
            end
            hsb_pkg::KIND_CLEAR_EN: begin
                if (is_write) begin
                    n_clear_armed = (r_wdata == hsb_pkg::CLEAR_MAGIC);
                end
            end
            hsb_pkg::KIND_VERSION: begin
                res_rdata = r_version_id;
            end
            hsb_pkg::KIND_TOKEN: begin
                if (!r_lock_version) begin
                    if (is_write) begin
                        if (r_wdata == r_free_v0) begin
                            n_taken[r_idx] = 1'b0;
                        end else if (!lock_hit) begin
                            n_taken[r_idx] = 1'b1;
                            mem_we         = 1'b1;
                        end
                    end else begin
                        res_rdata = lock_hit ? r_mem_rdata : r_free_v0;
                    end
                end else begin
                    if (is_write) begin
                        if (r_wdata == r_free_v1) begin
                            n_taken[r_idx] = 1'b0;
                        end
                    end else if (lock_hit) begin
                        res_rdata = r_mem_rdata;
                    end else begin
                        // read of a free lock takes it for the requester
                        n_taken[r_idx] = 1'b1;
                        mem_we         = 1'b1;
                        mem_wdata      = r_req_key;
                    end
                end
            end
            hsb_pkg::KIND_UNMAPPED: begin
                res_err = 1'b1;
            end
            default: begin
                res_err = 1'b1;
            end
        endcase

        if (is_write) begin
            res_rdata = '0;
        end
    end

    // owner-key memory: read on accept, write back on the execute cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_rdata <= mem_owner[dec_idx];
        end
        if (fire && mem_we) begin
            mem_owner[r_idx] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_req.opcode;
            r_kind    <= dec_kind;
            r_idx     <= dec_idx;
            r_wdata   <= i_req.write_data;
            r_req_key <= i_req.requester_key;
        end
        if (fire) begin
            r_out_rdata <= res_rdata;
            r_out_err   <= res_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= hsb_pkg::S_IDLE;
            r_taken       <= '0;
            r_clear_armed <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            unique case (r_state)
                hsb_pkg::S_IDLE: begin
                    if (accept) begin
                        r_state <= hsb_pkg::S_EXEC;
                    end
                end
                hsb_pkg::S_EXEC: begin
                    if (fire) begin
                        r_state <= hsb_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= hsb_pkg::S_IDLE;
                end
            endcase

            if (fire) begin
                r_taken       <= n_taken;
                r_clear_armed <= n_clear_armed;
                r_out_valid   <= 1'b1;
            end else if (o_rsp.ready) begin
                // drop the result once its transfer completes
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_version <= 1'b0;
            r_free_v0      <= '0;
            r_free_v1      <= '0;
            r_version_id   <= '0;
        end else if (i_cfg_we) begin
            unique case (hsb_pkg::t_cfg_idx'(i_cfg_idx))
                hsb_pkg::CFG_LOCK_VERSION: r_lock_version <= i_cfg_wdata[0];
                hsb_pkg::CFG_FREE_V0:      r_free_v0      <= i_cfg_wdata;
                hsb_pkg::CFG_FREE_V1:      r_free_v1      <= i_cfg_wdata;
                hsb_pkg::CFG_VERSION_ID:   r_version_id   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

endmodule

### design/hsb_checker.sv
// Port-level checks of the spinlock bank, attached to the top level by bind.
// Depends on hardware_spinlock_bank_unit and hsb_pkg.
module hsb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [hsb_pkg::DATA_W-1:0] i_rsp_read_data,
    input logic                       i_rsp_access_error
);

    // one access at a time: ready drops right after a request transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted back to back");

    // a new result appears only out of an execute cycle
    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(!i_req_ready))
        else $error("result without a preceding access");

    // an error result never carries data
    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_access_error) |-> (i_rsp_read_data == '0))
        else $error("error result with nonzero data");

    // no result is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_rsp_valid)
        else $error("result valid after reset");

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_read_data)))
        else $error("stalled result changed");

endmodule

bind hardware_spinlock_bank_unit hsb_checker u_hsb_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_read_data    (o_rsp.read_data),
    .i_rsp_access_error (o_rsp.access_error)
);
